FILE: design/d2c_pkg.sv
package d2c_pkg;

    localparam int D2C_COORD_BITS = 11;
    localparam int D2C_FRAC_BITS  = 16;

    // Coefficient table layout
    localparam int KI_BASE     = 0;
    localparam int K_BASE      = 9;
    localparam int XF_BASE     = 18;
    localparam int TABLE_WORDS = 34;

    // Quotient bits; magnitude limit of the saturating stages
    localparam int DIV_STEPS = 30;
    localparam logic [DIV_STEPS-1:0] SAT_LIM = '1;

    // Register stages of each unit
    localparam int PROJ_STAGES  = 8;
    localparam int DIV_STAGES   = DIV_STEPS + 3;
    localparam int COLOR_STAGES = 4;
    localparam int LATENCY      = PROJ_STAGES + DIV_STAGES + COLOR_STAGES;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    localparam logic [1:0] REG_COLOR_ROWS = 2'd0;
    localparam logic [1:0] REG_COLOR_COLS = 2'd1;
    localparam logic [1:0] REG_MIN_DEPTH  = 2'd2;

    typedef logic [10:0] coord_t;
    typedef logic signed [31:0] coef_word_t;
    typedef logic signed [63:0] wide_t;

    typedef struct packed {
        logic              command;
        logic [5:0]        coeff_index;
        logic signed [31:0] coeff_value;
        coord_t            pixel_x;
        coord_t            pixel_y;
        logic [15:0]       depth_value;
    } map_in_t;

    typedef struct packed {
        logic   mapped;
        coord_t color_row;
        coord_t color_col;
        coord_t out_x;
        coord_t out_y;
    } map_out_t;

    // Side data carried down the pipeline with each pixel
    typedef struct packed {
        logic   live;
        coord_t x;
        coord_t y;
    } tag_t;

    typedef struct packed {
        coef_word_t [8:0]  ki;
        coef_word_t [8:0]  k;
        coef_word_t [15:0] xf;
    } coef_set_t;

endpackage

FILE: design/d2c_coef.sv
module d2c_coef
    import d2c_pkg::*;
(
    input  logic       clk,
    input  logic       we,
    input  logic [5:0] index,
    input  coef_word_t data,
    output coef_set_t  coefs
);

    coef_word_t ki_reg [9];
    coef_word_t k_reg  [9];
    coef_word_t xf_reg [16];

    for (genvar i = 0; i < 9; i++) begin : g_ki
        always_ff @(posedge clk)
        begin
            if (we && index == 6'(KI_BASE + i))
            begin
                ki_reg[i] <= data;
            end
        end
    end

    for (genvar i = 0; i < 9; i++) begin : g_k
        always_ff @(posedge clk)
        begin
            if (we && index == 6'(K_BASE + i))
            begin
                k_reg[i] <= data;
            end
        end
    end

    for (genvar i = 0; i < 16; i++) begin : g_xf
        always_ff @(posedge clk)
        begin
            if (we && index == 6'(XF_BASE + i))
            begin
                xf_reg[i] <= data;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            coefs.ki[i] = ki_reg[i];
            coefs.k[i]  = k_reg[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            coefs.xf[i] = xf_reg[i];
        end
    end

endmodule

FILE: design/d2c_project.sv
module d2c_project
    import d2c_pkg::*;
#(
    parameter int COORD_BITS = D2C_COORD_BITS,
    parameter int FRAC_BITS  = D2C_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  coord_t      pixel_x,
    input  coord_t      pixel_y,
    input  logic [15:0] depth_value,
    input  logic [15:0] min_depth,
    input  coef_set_t   coefs,
    output logic        out_valid,
    output tag_t        out_tag,
    output wide_t       h [3],
    output logic        active
);

    localparam coord_t XMASK = coord_t'((64'd1 << COORD_BITS) - 64'd1);

    logic [PROJ_STAGES-1:0] v_reg;

    coord_t              s0_x_reg;
    coord_t              s0_y_reg;
    logic [15:0]         s0_d_reg;
    tag_t                tag_reg [PROJ_STAGES];

    logic signed [43:0]  mx_reg [3];
    logic signed [43:0]  my_reg [3];
    logic [15:0]         s1_d_reg;
    logic signed [46:0]  a_reg  [3];
    logic [15:0]         s2_d_reg;
    logic signed [63:0]  ad_reg [3];
    logic [63:0]         mag_reg [3];
    logic                neg_reg [3];
    logic signed [30:0]  p_reg  [3];
    logic signed [62:0]  pt_reg [3][3];
    wide_t               h_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[PROJ_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s0_x_reg   <= pixel_x & XMASK;
        s0_y_reg   <= pixel_y & XMASK;
        s0_d_reg   <= depth_value;
        tag_reg[0] <= '{live: (depth_value > min_depth), x: pixel_x, y: pixel_y};
        for (int s = 1; s < PROJ_STAGES; s++)
        begin
            tag_reg[s] <= tag_reg[s-1];
        end
        s1_d_reg <= s0_d_reg;
        s2_d_reg <= s1_d_reg;
        for (int j = 0; j < 3; j++)
        begin
            mx_reg[j] <= 44'($signed({1'b0, s0_x_reg})) * 44'($signed(coefs.ki[KI_BASE + j]));
            my_reg[j] <= 44'($signed({1'b0, s0_y_reg})) * 44'($signed(coefs.ki[KI_BASE + 3 + j]));
            a_reg[j]  <= 47'(mx_reg[j]) + 47'(my_reg[j]) + 47'($signed(coefs.ki[KI_BASE + 6 + j]));
            ad_reg[j] <= 64'(a_reg[j]) * 64'($signed({1'b0, s2_d_reg}));
            neg_reg[j] <= ad_reg[j][63];
            mag_reg[j] <= ad_reg[j][63] ? 64'(-ad_reg[j]) : 64'(ad_reg[j]);
            p_reg[j]  <= sat_sign(mag_reg[j] >> FRAC_BITS, neg_reg[j]);
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i][j] <= 63'(p_reg[i]) * 63'($signed(coefs.xf[4 * i + j]));
            end
            h_reg[j] <= 64'(pt_reg[0][j]) + 64'(pt_reg[1][j]) + 64'(pt_reg[2][j])
                      + 64'($signed(coefs.xf[12 + j]));
        end
    end

    function automatic logic signed [30:0] sat_sign(input logic [63:0] sh, input logic neg);
        logic [DIV_STEPS-1:0] m;
        m = (sh > 64'(SAT_LIM)) ? SAT_LIM : sh[DIV_STEPS-1:0];
        return neg ? -31'(m) : 31'(m);
    endfunction

    assign out_valid = v_reg[PROJ_STAGES-1];
    assign out_tag   = tag_reg[PROJ_STAGES-1];
    assign h         = h_reg;
    assign active    = |v_reg;

endmodule

FILE: design/d2c_divide.sv
module d2c_divide
    import d2c_pkg::*;
#(
    parameter int FRAC_BITS = D2C_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tag_t               in_tag,
    input  wide_t              h [3],
    output logic               out_valid,
    output tag_t               out_tag,
    output logic signed [30:0] u,
    output logic signed [30:0] v,
    output logic               active
);

    localparam int OVF_SH = DIV_STEPS - FRAC_BITS;

    typedef struct packed {
        logic [63:0]          rem0;
        logic [63:0]          rem1;
        logic [63:0]          dm;
        logic [DIV_STEPS-1:0] low0;
        logic [DIV_STEPS-1:0] low1;
        logic [DIV_STEPS-1:0] q0;
        logic [DIV_STEPS-1:0] q1;
        logic                 neg0;
        logic                 neg1;
        logic                 ovf0;
        logic                 ovf1;
        tag_t                 tag;
    } div_stage_t;

    logic        g_valid_reg;
    tag_t        g_tag_reg;
    logic [63:0] g_nm0_reg;
    logic [63:0] g_nm1_reg;
    logic [63:0] g_dm_reg;
    logic        g_neg0_reg;
    logic        g_neg1_reg;

    logic [DIV_STEPS:0] stv_reg;
    div_stage_t         st_reg [DIV_STEPS+1];
    div_stage_t         st0_next;

    logic               f_valid_reg;
    tag_t               f_tag_reg;
    logic signed [30:0] u_reg;
    logic signed [30:0] v_reg;

    // One restoring step for both quotients
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t  r;
        logic [64:0] t0;
        logic [64:0] t1;
        logic        ge0;
        logic        ge1;
        r   = s;
        t0  = {s.rem0, s.low0[DIV_STEPS-1]};
        t1  = {s.rem1, s.low1[DIV_STEPS-1]};
        ge0 = t0 >= {1'b0, s.dm};
        ge1 = t1 >= {1'b0, s.dm};
        r.rem0 = ge0 ? 64'(t0 - {1'b0, s.dm}) : t0[63:0];
        r.rem1 = ge1 ? 64'(t1 - {1'b0, s.dm}) : t1[63:0];
        r.low0 = s.low0 << 1;
        r.low1 = s.low1 << 1;
        r.q0   = {s.q0[DIV_STEPS-2:0], ge0};
        r.q1   = {s.q1[DIV_STEPS-2:0], ge1};
        return r;
    endfunction

    function automatic logic signed [30:0] apply_sign(input logic [DIV_STEPS-1:0] q,
                                                      input logic ovf, input logic neg);
        logic [DIV_STEPS-1:0] m;
        m = ovf ? SAT_LIM : q;
        return neg ? -31'(m) : 31'(m);
    endfunction

    always_comb
    begin
        st0_next      = '0;
        st0_next.dm   = g_dm_reg;
        st0_next.rem0 = g_nm0_reg >> OVF_SH;
        st0_next.rem1 = g_nm1_reg >> OVF_SH;
        st0_next.low0 = DIV_STEPS'(g_nm0_reg << FRAC_BITS);
        st0_next.low1 = DIV_STEPS'(g_nm1_reg << FRAC_BITS);
        // quotient reaches 2^30: saturate
        st0_next.ovf0 = {{OVF_SH{1'b0}}, g_nm0_reg} >= {g_dm_reg, {OVF_SH{1'b0}}};
        st0_next.ovf1 = {{OVF_SH{1'b0}}, g_nm1_reg} >= {g_dm_reg, {OVF_SH{1'b0}}};
        st0_next.neg0 = g_neg0_reg;
        st0_next.neg1 = g_neg1_reg;
        st0_next.tag  = g_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            stv_reg     <= '0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            g_valid_reg <= in_valid;
            stv_reg     <= {stv_reg[DIV_STEPS-1:0], g_valid_reg};
            f_valid_reg <= stv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        g_tag_reg      <= '{live: in_tag.live && (h[2] != '0), x: in_tag.x, y: in_tag.y};
        g_nm0_reg      <= h[0][63] ? 64'(-h[0]) : 64'(h[0]);
        g_nm1_reg      <= h[1][63] ? 64'(-h[1]) : 64'(h[1]);
        g_dm_reg       <= h[2][63] ? 64'(-h[2]) : 64'(h[2]);
        g_neg0_reg     <= h[0][63] ^ h[2][63];
        g_neg1_reg     <= h[1][63] ^ h[2][63];
        st_reg[0]      <= st0_next;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            st_reg[k] <= div_step(st_reg[k-1]);
        end
        f_tag_reg <= st_reg[DIV_STEPS].tag;
        u_reg <= apply_sign(st_reg[DIV_STEPS].q0, st_reg[DIV_STEPS].ovf0, st_reg[DIV_STEPS].neg0);
        v_reg <= apply_sign(st_reg[DIV_STEPS].q1, st_reg[DIV_STEPS].ovf1, st_reg[DIV_STEPS].neg1);
    end

    assign out_valid = f_valid_reg;
    assign out_tag   = f_tag_reg;
    assign u         = u_reg;
    assign v         = v_reg;
    assign active    = g_valid_reg | (|stv_reg) | f_valid_reg;

endmodule

FILE: design/d2c_color.sv
module d2c_color
    import d2c_pkg::*;
#(
    parameter int COORD_BITS = D2C_COORD_BITS,
    parameter int FRAC_BITS  = D2C_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tag_t               in_tag,
    input  logic signed [30:0] u,
    input  logic signed [30:0] v,
    input  coef_set_t          coefs,
    input  logic [11:0]        color_rows,
    input  logic [11:0]        color_cols,
    output logic               result_valid,
    output map_out_t           result,
    output logic               active
);

    localparam logic [63:0] CMASK = (64'd1 << COORD_BITS) - 64'd1;

    logic [COLOR_STAGES-1:0] v_reg;
    tag_t                    tag_reg [COLOR_STAGES-1];

    logic signed [62:0] pu_reg [2];
    logic signed [62:0] pv_reg [2];
    wide_t              s_reg  [2];
    logic [63:0]        mag_reg [2];
    logic               neg_reg [2];
    map_out_t           result_reg;

    logic row_ok;
    logic col_ok;
    logic ok;

    // index 0 is the column, index 1 the row
    assign col_ok = (!neg_reg[0] || mag_reg[0] == '0) && mag_reg[0] < 64'(color_cols)
                  && mag_reg[0] <= CMASK;
    assign row_ok = (!neg_reg[1] || mag_reg[1] == '0) && mag_reg[1] < 64'(color_rows)
                  && mag_reg[1] <= CMASK;
    assign ok     = tag_reg[COLOR_STAGES-2].live && row_ok && col_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[COLOR_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int s = 1; s < COLOR_STAGES - 1; s++)
        begin
            tag_reg[s] <= tag_reg[s-1];
        end
        for (int j = 0; j < 2; j++)
        begin
            pu_reg[j]  <= 63'(u) * 63'($signed(coefs.k[j]));
            pv_reg[j]  <= 63'(v) * 63'($signed(coefs.k[3 + j]));
            s_reg[j]   <= 64'(pu_reg[j]) + 64'(pv_reg[j])
                        + (64'($signed(coefs.k[6 + j])) <<< FRAC_BITS);
            neg_reg[j] <= s_reg[j][63];
            mag_reg[j] <= (s_reg[j][63] ? 64'(-s_reg[j]) : 64'(s_reg[j])) >> (2 * FRAC_BITS);
        end
        result_reg.mapped    <= ok;
        result_reg.color_row <= ok ? mag_reg[1][10:0] : '0;
        result_reg.color_col <= ok ? mag_reg[0][10:0] : '0;
        result_reg.out_x     <= tag_reg[COLOR_STAGES-2].x;
        result_reg.out_y     <= tag_reg[COLOR_STAGES-2].y;
    end

    assign result_valid = v_reg[COLOR_STAGES-1];
    assign result       = result_reg;
    assign active       = |v_reg;

endmodule

FILE: design/depth_to_color_pixel_mapper_core.sv
// Channel   Signals                                   Direction  Transaction
// command   start, busy, item (map_in_t)              in         start && !busy
// result    result_valid, result (map_out_t)          out        one cycle strobe
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// A map command enters every cycle while busy is low; its result passes through the
// projection, the 30-step pipelined quotient unit and the colour multiply stages.
// A load command writes its coefficient once the pipeline holds no map; busy stays
// high until then, so a load after maps waits; otherwise it is written at once.
// Reset clears the valid bits and pending load, sets size/depth to 1080/1920/1; the
// coefficient table holds no value until loaded. The receiver cannot stall results.
module depth_to_color_pixel_mapper_core
    import d2c_pkg::*;
#(
    parameter int COORD_BITS      = D2C_COORD_BITS,
    parameter int COEFF_FRAC_BITS = D2C_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  map_in_t     item,
    output logic        result_valid,
    output map_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [11:0] rows_reg;
    logic [11:0] cols_reg;
    logic [15:0] min_depth_reg;

    logic       pend_valid_reg;
    logic [5:0] pend_index_reg;
    coef_word_t pend_data_reg;

    logic       accept;
    logic       map_accept;
    logic       load_accept;
    logic       pipe_active;
    logic       coef_we;
    logic [5:0] coef_index;
    coef_word_t coef_data;
    coef_set_t  coefs;

    logic  proj_valid;
    tag_t  proj_tag;
    wide_t proj_h [3];
    logic  proj_active;

    logic               div_valid;
    tag_t               div_tag;
    logic signed [30:0] div_u;
    logic signed [30:0] div_v;
    logic               div_active;
    logic               color_active;

    assign accept      = start && !busy;
    assign map_accept  = accept && item.command == CMD_MAP;
    assign load_accept = accept && item.command == CMD_LOAD;
    assign busy        = pend_valid_reg;
    assign cfg_ready   = 1'b1;
    assign pipe_active = proj_active | div_active | color_active;

    // hold a load until no map in flight still reads the table
    assign coef_we    = !pipe_active && (pend_valid_reg || load_accept);
    assign coef_index = pend_valid_reg ? pend_index_reg : item.coeff_index;
    assign coef_data  = pend_valid_reg ? pend_data_reg : item.coeff_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg       <= 12'd1080;
            cols_reg       <= 12'd1920;
            min_depth_reg  <= 16'd1;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_COLOR_ROWS: rows_reg      <= cfg_data[11:0];
                    REG_COLOR_COLS: cols_reg      <= cfg_data[11:0];
                    REG_MIN_DEPTH:  min_depth_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (load_accept && pipe_active)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (coef_we)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            pend_index_reg <= item.coeff_index;
            pend_data_reg  <= item.coeff_value;
        end
    end

    d2c_coef u_coef (
        .clk   (clk),
        .we    (coef_we),
        .index (coef_index),
        .data  (coef_data),
        .coefs (coefs)
    );

    d2c_project #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (COEFF_FRAC_BITS)
    ) u_project (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (map_accept),
        .pixel_x     (item.pixel_x),
        .pixel_y     (item.pixel_y),
        .depth_value (item.depth_value),
        .min_depth   (min_depth_reg),
        .coefs       (coefs),
        .out_valid   (proj_valid),
        .out_tag     (proj_tag),
        .h           (proj_h),
        .active      (proj_active)
    );

    d2c_divide #(
        .FRAC_BITS (COEFF_FRAC_BITS)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (proj_valid),
        .in_tag    (proj_tag),
        .h         (proj_h),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .u         (div_u),
        .v         (div_v),
        .active    (div_active)
    );

    d2c_color #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (COEFF_FRAC_BITS)
    ) u_color (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (div_valid),
        .in_tag       (div_tag),
        .u            (div_u),
        .v            (div_v),
        .coefs        (coefs),
        .color_rows   (rows_reg),
        .color_cols   (cols_reg),
        .result_valid (result_valid),
        .result       (result),
        .active       (color_active)
    );

`ifndef SYNTHESIS
    a_table_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        coef_we |-> !pipe_active)
        else $error("coefficient written while a map is in flight");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(map_accept, LATENCY))
        else $error("result without a map transaction at the pipeline depth");

    a_pending_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !pipe_active) |=> !pend_valid_reg)
        else $error("pending load not written after pipeline drained");
`endif

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import d2c_pkg::*;

    localparam longint SAT_MAG    = (64'sd1 <<< 30) - 1;
    localparam int     IDLE_LIMIT = 3000;
    localparam int     PHASES     = 6;
    localparam int     PHASE_MAPS = 265;

    class map_scoreboard;
        longint     coef [TABLE_WORDS];
        logic [11:0] rows;
        logic [11:0] cols;
        logic [15:0] min_d;
        map_out_t   pending[$];
        int         errors;

        function new();
            rows = 12'd1080;
            cols = 12'd1920;
            min_d = 16'd1;
            errors = 0;
            foreach (coef[i]) coef[i] = 0;
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_COLOR_ROWS: rows = data[11:0];
                REG_COLOR_COLS: cols = data[11:0];
                REG_MIN_DEPTH:  min_d = data;
                default: ;
            endcase
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint trunc_shift(longint v, int s);
            longint m;
            m = mag(v) >>> s;
            return (v < 0) ? -m : m;
        endfunction

        function longint clamp(longint v);
            if (v > SAT_MAG) return SAT_MAG;
            if (v < -SAT_MAG) return -SAT_MAG;
            return v;
        endfunction

        // Q.F quotient, truncated toward zero, magnitude clamped
        function longint quotient(longint num, longint den);
            longint unsigned nm, dm, qi, r, f, m;
            bit neg;
            nm = mag(num);
            dm = mag(den);
            qi = nm / dm;
            r = nm % dm;
            f = 0;
            neg = (num < 0) != (den < 0);
            for (int k = 0; k < D2C_FRAC_BITS; k++) begin
                r = r << 1;
                f = f << 1;
                if (r >= dm) begin
                    r = r - dm;
                    f = f | 1;
                end
            end
            if (qi >= (64'd1 << (30 - D2C_FRAC_BITS)))
                m = SAT_MAG;
            else
                m = (qi << D2C_FRAC_BITS) | f;
            if (m > SAT_MAG) m = SAT_MAG;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function map_out_t project(map_in_t it);
            map_out_t o;
            longint x, y, d, a, s, u, v;
            longint p[3];
            longint h[3];
            longint c[2];
            bit ok;
            x = it.pixel_x;
            y = it.pixel_y;
            d = it.depth_value;
            ok = 0;
            c[0] = 0;
            c[1] = 0;
            if (d > min_d) begin
                for (int j = 0; j < 3; j++) begin
                    a = x * coef[KI_BASE + j] + y * coef[KI_BASE + 3 + j]
                        + coef[KI_BASE + 6 + j];
                    p[j] = clamp(trunc_shift(a * d, D2C_FRAC_BITS));
                end
                for (int j = 0; j < 3; j++) begin
                    s = coef[XF_BASE + 12 + j];
                    for (int i = 0; i < 3; i++) s += p[i] * coef[XF_BASE + 4 * i + j];
                    h[j] = s;
                end
                if (h[2] != 0) begin
                    u = quotient(h[0], h[2]);
                    v = quotient(h[1], h[2]);
                    for (int j = 0; j < 2; j++) begin
                        s = u * coef[K_BASE + j] + v * coef[K_BASE + 3 + j]
                            + coef[K_BASE + 6 + j] * (64'sd1 <<< D2C_FRAC_BITS);
                        c[j] = trunc_shift(s, 2 * D2C_FRAC_BITS);
                    end
                    // c[0] is the column, c[1] the row
                    ok = c[1] >= 0 && c[0] >= 0 && c[1] < rows && c[0] < cols
                         && c[1] <= 2047 && c[0] <= 2047;
                end
            end
            o.mapped = ok;
            o.color_row = ok ? coord_t'(c[1]) : '0;
            o.color_col = ok ? coord_t'(c[0]) : '0;
            o.out_x = it.pixel_x;
            o.out_y = it.pixel_y;
            return o;
        endfunction

        function void note_item(map_in_t it);
            if (it.command == CMD_LOAD) begin
                if (it.coeff_index < TABLE_WORDS)
                    coef[it.coeff_index] = longint'(it.coeff_value);
            end else begin
                pending.push_back(project(it));
            end
        endfunction

        task check_result(map_out_t got);
            map_out_t exp_r;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp_r = pending.pop_front();
            if (got.mapped !== exp_r.mapped)
                report($sformatf("mapped %b, want %b", got.mapped, exp_r.mapped));
            if (got.color_row !== exp_r.color_row)
                report($sformatf("color_row %0d, want %0d", got.color_row, exp_r.color_row));
            if (got.color_col !== exp_r.color_col)
                report($sformatf("color_col %0d, want %0d", got.color_col, exp_r.color_col));
            if (got.out_x !== exp_r.out_x)
                report($sformatf("out_x %0d, want %0d", got.out_x, exp_r.out_x));
            if (got.out_y !== exp_r.out_y)
                report($sformatf("out_y %0d, want %0d", got.out_y, exp_r.out_y));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    map_in_t     item;
    logic        result_valid;
    map_out_t    result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    map_scoreboard sb;
    int  quiet_cycles;
    bit  calm;
    coef_word_t nominal [TABLE_WORDS];

    depth_to_color_pixel_mapper_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task pause_start();
        if (!calm && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task send(map_in_t it);
        pause_start();
        item <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(it);
    endtask

    task load_word(int idx, coef_word_t val);
        map_in_t it;
        it = '0;
        it.command = CMD_LOAD;
        it.coeff_index = idx[5:0];
        it.coeff_value = val;
        it.pixel_x = coord_t'($urandom);
        it.pixel_y = coord_t'($urandom);
        it.depth_value = 16'($urandom);
        send(it);
    endtask

    task map_pixel(int x, int y, int d);
        map_in_t it;
        it = '0;
        it.command = CMD_MAP;
        it.coeff_index = 6'($urandom);
        it.coeff_value = $urandom;
        it.pixel_x = coord_t'(x);
        it.pixel_y = coord_t'(y);
        it.depth_value = d[15:0];
        send(it);
    endtask

    // Drain, then let loads that cause no result finish inside the block
    task settle();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Pinhole camera pair with a rigid transform, perturbed when jitter is set
    task build_table(int fx, int cx, int cy, bit jitter);
        foreach (nominal[i]) nominal[i] = '0;
        nominal[KI_BASE + 0] = 65536 / fx;
        nominal[KI_BASE + 4] = 65536 / fx;
        nominal[KI_BASE + 6] = -(cx * 65536) / fx;
        nominal[KI_BASE + 7] = -(cy * 65536) / fx;
        nominal[KI_BASE + 8] = 65536;
        nominal[K_BASE + 0] = fx * 65536;
        nominal[K_BASE + 4] = fx * 65536;
        nominal[K_BASE + 6] = cx * 65536;
        nominal[K_BASE + 7] = cy * 65536;
        nominal[K_BASE + 8] = 65536;
        for (int i = 0; i < 3; i++) nominal[XF_BASE + 5 * i] = 65536;
        nominal[XF_BASE + 15] = 65536;
        if (jitter) begin
            for (int i = 0; i < 16; i++)
                nominal[XF_BASE + i] += $signed($urandom_range(0, 4000)) - 2000;
            for (int j = 0; j < 3; j++)
                nominal[XF_BASE + 12 + j] = ($signed($urandom_range(0, 100)) - 50) * 65536;
            nominal[K_BASE + 6] += ($signed($urandom_range(0, 600)) - 300) * 65536;
        end
        for (int i = 0; i < TABLE_WORDS; i++) load_word(i, nominal[i]);
    endtask

    task random_item(int rows_hint, int cols_hint);
        int pick;
        int d;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            load_word($urandom_range(0, 33), $urandom);
        end else if (pick < 6) begin
            load_word($urandom_range(TABLE_WORDS, 63), $urandom);
        end else if (pick < 10) begin
            int w;
            w = $urandom_range(0, 33);
            nominal[w] += $signed($urandom_range(0, 200)) - 100;
            load_word(w, nominal[w]);
        end else begin
            case ($urandom_range(0, 3))
                0: d = $urandom_range(0, 65535);
                1: d = sb.min_d + $signed($urandom_range(0, 4)) - 2;
                default: d = $urandom_range(300, 8000);
            endcase
            if ($urandom_range(0, 3) == 0)
                map_pixel($urandom_range(0, 2047), $urandom_range(0, 2047), d);
            else
                map_pixel($urandom_range(0, cols_hint), $urandom_range(0, rows_hint), d);
        end
    endtask

    initial begin
        logic [15:0] rows_set [PHASES];
        logic [15:0] cols_set [PHASES];
        logic [15:0] mind_set [PHASES];

        rows_set = '{16'd1080, 16'd2048, 16'd1, 16'd0, 16'hFFFF, 16'd1080};
        cols_set = '{16'd1920, 16'd2048, 16'd1, 16'd2048, 16'd1500, 16'd1920};
        mind_set = '{16'd1, 16'd0, 16'd0, 16'd300, 16'hFFFF, 16'd100};

        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_cycles = 0;
        calm = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: borders, depth threshold, zero divisor, ignored load
        write_reg(REG_COLOR_ROWS, 16'd1080);
        write_reg(REG_COLOR_COLS, 16'd1920);
        write_reg(REG_MIN_DEPTH, 16'd1);
        build_table(500, 960, 540, 0);
        map_pixel(960, 540, 1000);
        map_pixel(0, 0, 1000);
        map_pixel(2047, 2047, 1000);
        map_pixel(1919, 1079, 2000);
        map_pixel(500, 500, 0);
        map_pixel(500, 500, 1);
        map_pixel(500, 500, 2);
        map_pixel(500, 500, 65535);
        map_pixel(2047, 0, 65535);
        map_pixel(0, 2047, 3000);
        load_word(63, 32'h7FFF_FFFF);
        load_word(34, 32'h8000_0000);
        map_pixel(100, 900, 1500);
        for (int r = 0; r < 3; r++) load_word(XF_BASE + 4 * r + 2, '0);
        load_word(XF_BASE + 14, '0);
        map_pixel(700, 300, 2500);
        map_pixel(1200, 100, 800);
        load_word(KI_BASE, 32'h8000_0000);
        load_word(XF_BASE, 32'h7FFF_FFFF);
        map_pixel(300, 300, 4000);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            int rh;
            int ch;
            calm = (ph == PHASES - 1);
            write_reg(REG_COLOR_ROWS, rows_set[ph]);
            write_reg(REG_COLOR_COLS, cols_set[ph]);
            write_reg(REG_MIN_DEPTH, mind_set[ph]);
            write_reg(2'd3, 16'($urandom));
            rh = (rows_set[ph][11:0] == 0) ? 100 : rows_set[ph][11:0];
            ch = (cols_set[ph][11:0] == 0) ? 100 : cols_set[ph][11:0];
            if (rh > 2047) rh = 2047;
            if (ch > 2047) ch = 2047;
            if (ph == 2) begin
                for (int i = 0; i < TABLE_WORDS; i++) begin
                    nominal[i] = $urandom;
                    load_word(i, nominal[i]);
                end
            end else begin
                build_table($urandom_range(300, 700), ch / 2, rh / 2, 1);
            end
            for (int n = 0; n < PHASE_MAPS; n++) random_item(rh, ch);
            settle();
        end

        start <= 1'b0;
        repeat (LATENCY + 5) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: depth_to_color_pixel_mapper_core.f
design/d2c_pkg.sv
design/d2c_coef.sv
design/d2c_project.sv
design/d2c_divide.sv
design/d2c_color.sv
design/depth_to_color_pixel_mapper_core.sv
verif/tb_top.sv
